// ----- hw/rtl/ccs_pkg.sv -----
package ccs_pkg;

    localparam int TAG_LENGTH = 8;
    localparam int FILL_W     = $clog2(TAG_LENGTH + 1);

    localparam logic [7:0] OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CLOSE_BRACE = 8'h7D;

    typedef logic [TAG_LENGTH-1:0][7:0] window_t;
    typedef logic [FILL_W-1:0]          fill_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_present;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } push_t;

endpackage

// ----- hw/rtl/ccs_tag_match.sv -----
module ccs_tag_match (
    input  ccs_pkg::window_t window,
    output logic             match
);

    function automatic logic is_hex(input logic [7:0] c);
        logic digit;
        logic upper;
        logic lower;
        digit = (c >= 8'h30) && (c <= 8'h39);
        upper = (c >= 8'h41) && (c <= 8'h46);
        lower = (c >= 8'h61) && (c <= 8'h66);
        return digit || upper || lower;
    endfunction

    logic [ccs_pkg::TAG_LENGTH-1:0] ok;

    always_comb
    begin
        ok[0] = (window[0] == ccs_pkg::OPEN_BRACE);
        ok[ccs_pkg::TAG_LENGTH-1] =
            (window[ccs_pkg::TAG_LENGTH-1] == ccs_pkg::CLOSE_BRACE);
        for (int k = 1; k < ccs_pkg::TAG_LENGTH - 1; k++)
        begin
            ok[k] = is_hex(window[k]);
        end
    end

    assign match = &ok;

endmodule

// ----- hw/rtl/ccs_window.sv -----
module ccs_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ccs_pkg::in_item_t item,
    input  logic              queue_full,
    output ccs_pkg::push_t    push
);

    localparam int TL = ccs_pkg::TAG_LENGTH;

    ccs_pkg::window_t win_reg;
    ccs_pkg::window_t win_next;
    ccs_pkg::fill_t   fill_reg;
    ccs_pkg::fill_t   fill_next;
    logic             flushing_reg;
    logic             flushing_next;

    ccs_pkg::window_t win_add;
    ccs_pkg::window_t win_shift;
    ccs_pkg::window_t win_chk;
    ccs_pkg::window_t win_drain;
    ccs_pkg::fill_t   fill_add;
    ccs_pkg::fill_t   fill_chk;
    logic             full;
    logic             tag_hit;
    logic             emit;
    logic             accept;

    ccs_tag_match u_match (
        .window (win_add),
        .match  (tag_hit)
    );

    assign item_ready = !flushing_reg && !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        // append the new byte at the fill position
        for (int k = 0; k < TL; k++)
        begin
            win_add[k] = (item.byte_present && (fill_reg == ccs_pkg::fill_t'(k)))
                       ? item.data_byte : win_reg[k];
        end
        fill_add = fill_reg + ccs_pkg::fill_t'(item.byte_present);
        full     = (fill_add == ccs_pkg::fill_t'(TL));

        for (int k = 0; k < TL - 1; k++)
        begin
            win_shift[k] = win_add[k + 1];
            win_drain[k] = win_reg[k + 1];
        end
        win_shift[TL-1] = win_add[TL-1];
        win_drain[TL-1] = win_reg[TL-1];

        emit     = full && !tag_hit;
        win_chk  = emit ? win_shift : win_add;
        fill_chk = full ? (tag_hit ? '0 : ccs_pkg::fill_t'(TL - 1)) : fill_add;
    end

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        flushing_next = flushing_reg;
        push          = '0;
        if (flushing_reg)
        begin
            // drain one held byte per cycle while the output queue is not full
            if (!queue_full)
            begin
                push.valid            = 1'b1;
                push.item.out_byte    = win_reg[0];
                push.item.out_present = 1'b1;
                push.item.out_last    = (fill_reg == ccs_pkg::fill_t'(1));
                win_next              = win_drain;
                fill_next             = fill_reg - ccs_pkg::fill_t'(1);
                if (fill_reg == ccs_pkg::fill_t'(1))
                begin
                    flushing_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            win_next  = win_chk;
            fill_next = fill_chk;
            if (emit)
            begin
                push.valid            = 1'b1;
                push.item.out_byte    = win_add[0];
                push.item.out_present = 1'b1;
                push.item.out_last    = 1'b0;
            end
            if (item.end_of_text)
            begin
                if (fill_chk == '0)
                begin
                    // nothing left: send an end-only marker
                    push.valid            = 1'b1;
                    push.item.out_byte    = '0;
                    push.item.out_present = 1'b0;
                    push.item.out_last    = 1'b1;
                end
                else
                begin
                    flushing_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            flushing_reg <= flushing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

// ----- hw/rtl/ccs_out_queue.sv -----
module ccs_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ccs_pkg::push_t     push,
    output logic               full,
    output logic               result_valid,
    input  logic               result_ready,
    output ccs_pkg::out_item_t result
);

    ccs_pkg::out_item_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               pop;

    assign full         = (count_reg == 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ----- hw/rtl/colour_code_stripper_unit.sv -----
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | item_valid / item_ready    | item   (data_byte, byte_present, end_of_text)
// output   | result_valid / result_ready| result (out_byte, out_present, out_last)
//
// One byte item is taken per cycle while item_ready is high; bytes it releases
// land in a two-entry output queue the next cycle. An end item whose window still
// holds bytes drains them, one a cycle while the queue has room; item_ready is low.
// Reset clears the fill count, drain flag and queue pointers; window bytes
// are not reset. item_ready drops whenever the output queue is full.
module colour_code_stripper_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ccs_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output ccs_pkg::out_item_t result
);

    ccs_pkg::push_t push;
    logic           queue_full;

    ccs_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push)
    );

    ccs_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (queue_full),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
